### hw/rtl/dsdq_pkg.sv
// Shared types and constants for the depth-sorted draw queue.
// Used by dsdq_cell and depth_sorted_draw_queue_core; depends on nothing else.
package dsdq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_SORT  = 2'd2;

  typedef struct packed {
    logic signed [31:0] depth;
    logic signed [15:0] prio;
    logic [14:0]        index;
    logic [3:0]         kind;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             insert;
    logic             rotate;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // True when entry a must be drawn strictly before entry b.
  function automatic logic goes_before(entry_t a, entry_t b);
    logic res;
    if (a.depth != b.depth) begin
      res = (a.depth < b.depth);
    end else begin
      res = (a.prio > b.prio);
    end
    return res;
  endfunction

endpackage

### hw/rtl/depth_sorted_draw_queue_core.sv
// Depth-sorted draw queue (painter's order), top level.
// Depends on dsdq_pkg and instantiates a chain of dsdq_cell slots.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low. in_command selects clear, add or sort-and-emit. Every result appears on
// the out_ ports for exactly one cycle, marked by out_strobe; the receiver
// cannot stall the block, so results are simply presented and gone.
// The queue is kept sorted at all times: an add slots its entry into the
// chain of cells in a single step (ascending depth, higher priority first at
// equal depth, earlier adds first at equal keys). Clear, add and unknown commands
// return one status result in the cycle after the request, and busy stays low,
// so such requests may be issued on every cycle.
// A sort request with N held entries raises busy while the chain rotates
// its head out one entry per cycle; each of the N results follows in the cycle
// after its rotation, the last one carrying out_last. The rotation leaves the
// queue in its sorted order. A sort of an empty queue returns one status result.
// So adds run at one per cycle while busy is low and emission at one entry
// per cycle, set by the single-step shift and rotate of the cell chain.
// Reset (rst_n low, synchronous) empties the queue, clears the overflow flag,
// returns the sequencer to idle and drops out_strobe.
module depth_sorted_draw_queue_core import dsdq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_command,
  input  logic signed [15:0]      in_priority_req,
  input  logic [14:0]             in_item_index,
  input  logic signed [31:0]      in_depth,
  input  logic [3:0]              in_kind,
  output logic                    out_strobe,
  output logic                    out_entry_valid,
  output logic signed [15:0]      out_priority,
  output logic [14:0]             out_index,
  output logic signed [31:0]      out_depth,
  output logic [3:0]              out_kind,
  output logic                    out_accepted,
  output logic [CNT_W-1:0]        out_entry_count,
  output logic                    out_overflowed,
  output logic                    out_last
);

  // Sequencer state.
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] emit_cnt_r, emit_cnt_nxt;

  // Result register: one result per cycle, shown for one cycle.
  logic             strobe_r, strobe_nxt;
  logic             valid_r, valid_nxt;
  entry_t           res_ent_r, res_ent_nxt;
  logic             acc_r, acc_nxt;
  logic [CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic             res_ovf_r, res_ovf_nxt;
  logic             last_r, last_nxt;

  logic             req_take;
  logic             emit_last;
  entry_t           new_ent;
  cell_ctl_t        ctl;
  entry_t           cell_ent   [CAPACITY];
  logic             cell_shift [CAPACITY];

  assign busy     = (state_r == ST_EMIT);
  assign req_take = start && !busy;

  assign new_ent.depth = in_depth;
  assign new_ent.prio  = in_priority_req;
  assign new_ent.index = in_item_index;
  assign new_ent.kind  = in_kind;

  assign emit_last = (CNT_W'(emit_cnt_r + 1'b1) == count_r);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    emit_cnt_nxt = emit_cnt_r;
    ctl.insert   = 1'b0;
    ctl.rotate   = 1'b0;
    ctl.count    = count_r;
    strobe_nxt   = 1'b0;
    valid_nxt    = 1'b0;
    res_ent_nxt  = '0;
    acc_nxt      = 1'b0;
    last_nxt     = 1'b0;

    if (state_r == ST_EMIT) begin
      // Present the head and rotate the occupied cells by one place.
      ctl.rotate   = 1'b1;
      strobe_nxt   = 1'b1;
      valid_nxt    = 1'b1;
      res_ent_nxt  = cell_ent[0];
      last_nxt     = emit_last;
      emit_cnt_nxt = CNT_W'(emit_cnt_r + 1'b1);
      if (emit_last) begin
        state_nxt = ST_IDLE;
      end
    end else if (req_take) begin
      case (in_command)
        CMD_CLEAR: begin
          count_nxt  = '0;
          ovf_nxt    = 1'b0;
          strobe_nxt = 1'b1;
          last_nxt   = 1'b1;
        end
        CMD_ADD: begin
          if (count_r == CNT_W'(CAPACITY)) begin
            ovf_nxt = 1'b1;
          end else begin
            ctl.insert = 1'b1;
            count_nxt  = CNT_W'(count_r + 1'b1);
            acc_nxt    = 1'b1;
          end
          strobe_nxt = 1'b1;
          last_nxt   = 1'b1;
        end
        CMD_SORT: begin
          if (count_r == '0) begin
            strobe_nxt = 1'b1;
            last_nxt   = 1'b1;
          end else begin
            state_nxt    = ST_EMIT;
            emit_cnt_nxt = '0;
          end
        end
        default: begin
          // Unused code: status only, nothing changes.
          strobe_nxt = 1'b1;
          last_nxt   = 1'b1;
        end
      endcase
    end

    res_cnt_nxt = count_nxt;
    res_ovf_nxt = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      emit_cnt_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    valid_r   <= valid_nxt;
    res_ent_r <= res_ent_nxt;
    acc_r     <= acc_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_ovf_r <= res_ovf_nxt;
    last_r    <= last_nxt;
  end

  // The chain: cell 0 is the head (drawn first). Each cell sees its left
  // neighbor for insertion shifts and its right neighbor for rotation.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_ent;
    logic   left_shift;
    entry_t right_ent;

    if (g == 0) begin : g_head
      assign left_ent   = new_ent;
      assign left_shift = 1'b0;
    end else begin : g_body
      assign left_ent   = cell_ent[g-1];
      assign left_shift = cell_shift[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_ent = cell_ent[0];
    end else begin : g_mid
      assign right_ent = cell_ent[g+1];
    end

    dsdq_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(g)),
      .ctl        (ctl),
      .new_ent    (new_ent),
      .left_ent   (left_ent),
      .left_shift (left_shift),
      .right_ent  (right_ent),
      .head_ent   (cell_ent[0]),
      .ent        (cell_ent[g]),
      .shift      (cell_shift[g])
    );
  end

  assign out_strobe      = strobe_r;
  assign out_entry_valid = valid_r;
  assign out_priority    = res_ent_r.prio;
  assign out_index       = res_ent_r.index;
  assign out_depth       = res_ent_r.depth;
  assign out_kind        = res_ent_r.kind;
  assign out_accepted    = acc_r;
  assign out_entry_count = res_cnt_r;
  assign out_overflowed  = res_ovf_r;
  assign out_last        = last_r;

  // Emission only ever runs over a non-empty queue.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (count_r != '0))
    else $error("emission running with an empty queue");

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(CAPACITY)))
    else $error("entry count beyond capacity");

  // The final sorted entry is shown only once the sequencer is idle again.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && valid_r && last_r) |-> !busy)
    else $error("busy still high after final sorted entry");

  // A stored add grows the queue by exactly one entry.
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && acc_r) |-> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("accepted add did not grow the queue by one");

endmodule

### hw/rtl/dsdq_cell.sv
// One slot of the sorted insertion chain.
// Depends on dsdq_pkg for entry_t, cell_ctl_t and the key comparison.
module dsdq_cell import dsdq_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  entry_t           new_ent,
  input  entry_t           left_ent,
  input  logic             left_shift,
  input  entry_t           right_ent,
  input  entry_t           head_ent,
  output entry_t           ent,
  output logic             shift
);

  entry_t           ent_r;
  entry_t           ent_nxt;
  logic [CNT_W-1:0] idx_ext;
  logic             occupied;
  logic             at_count;
  logic             is_tail;

  assign idx_ext  = CNT_W'(cell_idx);
  assign occupied = (idx_ext < ctl.count);
  assign at_count = (idx_ext == ctl.count);
  assign is_tail  = (CNT_W'(idx_ext + 1'b1) == ctl.count);

  // The held entries are sorted, so the cells that give way to a new entry
  // form a contiguous run that ends at the first free cell.
  assign shift = (occupied && goes_before(new_ent, ent_r)) || at_count;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.insert && shift) begin
      ent_nxt = left_shift ? left_ent : new_ent;
    end else if (ctl.rotate && occupied) begin
      ent_nxt = is_tail ? head_ent : right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule
